>>> sv/pds_pkg.sv
package pds_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam logic FUNC_REG  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_FIRE = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_LT  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [62:0] now_ns;
        logic [47:0] period_ns;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        status;
        logic [63:0] earliest_deadline;
        logic        any_pending;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [47:0] period;
        logic [63:0] deadline;
    } t_entry;

    typedef struct packed {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

endpackage

>>> sv/pds_stream_if.sv
interface pds_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> sv/periodic_deadline_scheduler.sv
// Registration: the slot is written in S_REG, then a minimum scan over all N = NUM_SLOTS
// slots precedes the result from S_FIN. Tick firing F slots: (F+1) selection scans, a
// deadline update per fired slot (read, add, compare, re-add if still past), one result per
// fired slot but the last, a final minimum scan and the closing result; output stalls hold
// S_PUSH and S_FIN. One transaction is in work at a time; the next is accepted in S_IDLE.
// Reset clears the slot valid bits and all control state; the slot tables are not cleared.
module periodic_deadline_scheduler #(
    parameter int NUM_SLOTS = pds_pkg::NUM_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pds_stream_if.sink    i_in,
    pds_stream_if.source  o_out
);
    import pds_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_SLOTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_REG      = 4'd1;
    localparam logic [3:0] S_SEL      = 4'd2;
    localparam logic [3:0] S_MIN      = 4'd3;
    localparam logic [3:0] S_PUSH     = 4'd4;
    localparam logic [3:0] S_UPD_RD   = 4'd5;
    localparam logic [3:0] S_UPD_ADD  = 4'd6;
    localparam logic [3:0] S_UPD_CMP  = 4'd7;
    localparam logic [3:0] S_UPD_ADD2 = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    function automatic logic [3:0] slot_field(input logic [SW-1:0] idx);
        logic [SW+3:0] w;
        w = {4'b0, idx};
        return w[3:0];
    endfunction

    logic [3:0]           r_state, n_state;
    logic                 r_func, n_func;
    logic [62:0]          r_now, n_now;
    logic [47:0]          r_period, n_period;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [SW-1:0]        r_cmp_idx, n_cmp_idx;
    logic                 r_found, n_found;
    logic [63:0]          r_best, n_best;
    logic [SW-1:0]        r_pick, n_pick;
    logic [63:0]          r_sum, n_sum;
    logic                 r_have_prev, n_have_prev;
    logic [SW-1:0]        r_prev_slot, n_prev_slot;
    logic [SW-1:0]        r_reg_slot, n_reg_slot;
    logic                 r_reg_full, n_reg_full;
    logic                 r_out_vld, n_out_vld;
    t_out                 r_out, n_out;

    logic                 s_free_found;
    logic [SW-1:0]        s_free_idx;
    logic                 s_out_free;
    logic                 s_we;
    logic [SW-1:0]        s_waddr;
    t_entry               s_wdata;
    logic [SW-1:0]        s_raddr;
    t_entry               s_rdata;
    t_alu_req             s_alu_req;
    logic [63:0]          s_alu_res;
    logic                 s_lt;
    logic                 s_scan;

    pds_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    pds_alu u_alu (
        .i_req (s_alu_req),
        .o_res (s_alu_res)
    );

    assign s_lt       = s_alu_res[0];
    assign s_out_free = !r_out_vld || o_out.ready;
    assign s_scan     = (r_state == S_SEL) || (r_state == S_MIN);

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_comb begin
        s_free_found = 1'b0;
        s_free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                s_free_found = 1'b1;
                s_free_idx   = SW'(i);
            end
        end
    end

    always_comb begin
        if (s_scan && (r_idx != LAST_CNT)) begin
            s_raddr = r_idx[SW-1:0];
        end else if (s_scan) begin
            s_raddr = '0;
        end else begin
            s_raddr = r_pick;
        end
    end

    always_comb begin
        s_alu_req.op = ALU_ADD;
        s_alu_req.a  = '0;
        s_alu_req.b  = '0;
        case (r_state)
            S_REG: begin
                s_alu_req.op = ALU_ADD;
                s_alu_req.a  = {1'b0, r_now};
                s_alu_req.b  = {16'b0, r_period};
            end
            S_SEL: begin
                s_alu_req.op = ALU_LT;
                s_alu_req.a  = s_rdata.deadline;
                s_alu_req.b  = r_found ? r_best : {1'b0, r_now};
            end
            S_MIN: begin
                s_alu_req.op = ALU_LT;
                s_alu_req.a  = s_rdata.deadline;
                s_alu_req.b  = r_best;
            end
            S_UPD_ADD: begin
                s_alu_req.op = ALU_ADD;
                s_alu_req.a  = s_rdata.deadline;
                s_alu_req.b  = {16'b0, s_rdata.period};
            end
            S_UPD_CMP: begin
                s_alu_req.op = ALU_LT;
                s_alu_req.a  = r_sum;
                s_alu_req.b  = {1'b0, r_now};
            end
            S_UPD_ADD2: begin
                s_alu_req.op = ALU_ADD;
                s_alu_req.a  = {1'b0, r_now};
                s_alu_req.b  = {16'b0, s_rdata.period};
            end
            default: begin
                s_alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_now       = r_now;
        n_period    = r_period;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_pick      = r_pick;
        n_sum       = r_sum;
        n_have_prev = r_have_prev;
        n_prev_slot = r_prev_slot;
        n_reg_slot  = r_reg_slot;
        n_reg_full  = r_reg_full;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out       = r_out;
        s_we        = 1'b0;
        s_waddr     = r_pick;
        s_wdata     = s_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func    = i_in.data.func;
                    n_now     = i_in.data.now_ns;
                    n_period  = i_in.data.period_ns;
                    n_state   = (i_in.data.func == FUNC_REG) ? S_REG : S_SEL;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_found   = 1'b0;
                end
            end
            S_REG: begin
                if (s_free_found) begin
                    s_we                = 1'b1;
                    s_waddr             = s_free_idx;
                    s_wdata.period      = r_period;
                    s_wdata.deadline    = s_alu_res;
                    n_valid[s_free_idx] = 1'b1;
                    n_reg_slot          = s_free_idx;
                    n_reg_full          = 1'b0;
                end else begin
                    n_reg_slot = '0;
                    n_reg_full = 1'b1;
                end
                n_state   = S_MIN;
                n_idx     = '0;
                n_cmp_vld = 1'b0;
                n_found   = 1'b0;
            end
            S_SEL, S_MIN: begin
                n_cmp_vld = (r_idx != LAST_CNT);
                n_cmp_idx = r_idx[SW-1:0];
                if (r_idx != LAST_CNT) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_cmp_vld && r_valid[r_cmp_idx]
                    && (s_lt || ((r_state == S_MIN) && !r_found))) begin
                    n_found = 1'b1;
                    n_best  = s_rdata.deadline;
                    n_pick  = r_cmp_idx;
                end
                if ((r_idx == LAST_CNT) && !r_cmp_vld) begin
                    if (r_state == S_MIN) begin
                        n_state = S_FIN;
                    end else if (r_found) begin
                        n_state = r_have_prev ? S_PUSH : S_UPD_RD;
                    end else begin
                        n_state   = S_MIN;
                        n_idx     = '0;
                        n_cmp_vld = 1'b0;
                        n_found   = 1'b0;
                    end
                end
            end
            S_PUSH: begin
                if (s_out_free) begin
                    n_out_vld               = 1'b1;
                    n_out.kind              = KIND_FIRE;
                    n_out.slot              = slot_field(r_prev_slot);
                    n_out.status            = 1'b0;
                    n_out.earliest_deadline = '0;
                    n_out.any_pending       = |r_valid;
                    n_out.last              = 1'b0;
                    n_state                 = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                n_have_prev = 1'b1;
                n_prev_slot = r_pick;
                n_state     = S_UPD_ADD;
            end
            S_UPD_ADD: begin
                n_sum   = s_alu_res;
                n_state = S_UPD_CMP;
            end
            S_UPD_CMP: begin
                if (s_lt) begin
                    n_state = S_UPD_ADD2;
                end else begin
                    s_we             = 1'b1;
                    s_wdata.deadline = r_sum;
                    n_state          = S_SEL;
                    n_idx            = '0;
                    n_cmp_vld        = 1'b0;
                    n_found          = 1'b0;
                end
            end
            S_UPD_ADD2: begin
                s_we             = 1'b1;
                s_wdata.deadline = s_alu_res;
                n_state          = S_SEL;
                n_idx            = '0;
                n_cmp_vld        = 1'b0;
                n_found          = 1'b0;
            end
            S_FIN: begin
                if (s_out_free) begin
                    n_out_vld = 1'b1;
                    if (r_func == FUNC_REG) begin
                        n_out.kind   = KIND_REG;
                        n_out.slot   = r_reg_full ? 4'd0 : slot_field(r_reg_slot);
                        n_out.status = r_reg_full;
                    end else if (r_have_prev) begin
                        n_out.kind   = KIND_FIRE;
                        n_out.slot   = slot_field(r_prev_slot);
                        n_out.status = 1'b0;
                    end else begin
                        n_out.kind   = KIND_IDLE;
                        n_out.slot   = 4'd0;
                        n_out.status = 1'b0;
                    end
                    n_out.earliest_deadline = r_found ? r_best : 64'd0;
                    n_out.any_pending       = |r_valid;
                    n_out.last              = 1'b1;
                    n_have_prev             = 1'b0;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_idx       <= n_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_have_prev <= n_have_prev;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_now       <= n_now;
        r_period    <= n_period;
        r_cmp_idx   <= n_cmp_idx;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_sum       <= n_sum;
        r_prev_slot <= n_prev_slot;
        r_reg_slot  <= n_reg_slot;
        r_reg_full  <= n_reg_full;
        r_out       <= n_out;
    end

    a_idle_no_held_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_have_prev)
        else $error("A fired result is still held while the block is idle.");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_we |-> ((r_state == S_REG) || (r_state == S_UPD_CMP) || (r_state == S_UPD_ADD2)))
        else $error("The slot table is written outside a registration or an update.");

    a_pick_is_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEL) && r_found) |-> (r_best < {1'b0, r_now}))
        else $error("The selected slot is not due.");

    a_final_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && s_out_free) |=> ((r_state == S_IDLE) && r_out_vld
                                                 && r_out.last))
        else $error("The closing result did not end the transaction.");

endmodule

>>> sv/pds_alu.sv
module pds_alu (
    input  pds_pkg::t_alu_req i_req,
    output logic [63:0]       o_res
);
    import pds_pkg::*;

    always_comb begin
        if (i_req.op == ALU_LT) begin
            o_res = {63'b0, (i_req.a < i_req.b)};
        end else begin
            o_res = i_req.a + i_req.b;
        end
    end
endmodule

>>> sv/pds_mem.sv
module pds_mem #(
    parameter int DEPTH = pds_pkg::NUM_SLOTS_DEF,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pds_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pds_pkg::t_entry o_rdata
);
    import pds_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
